// ----- rtl/tsn_pkg.sv -----
// ----------------------------------------------------------------------------
// tsn_pkg: timestamp shift and normalize package
// word types, widths, calendar constants and small calendar helpers
// ----------------------------------------------------------------------------
`default_nettype none

package tsn_pkg;

  // width of the signed millisecond shift
  localparam int SHIFT_BITS = 40;

  // millisecond total: shift plus up to 511 days of time of day, signed
  localparam int TOT_W = ((SHIFT_BITS > 37) ? SHIFT_BITS : 37) + 2;
  // width of the shared subtract / compare unit
  localparam int U_W   = TOT_W;

  localparam longint unsigned DAY_MS  = 64'd86400000;
  localparam longint unsigned HOUR_MS = 64'd3600000;
  localparam longint unsigned MIN_MS  = 64'd60000;
  localparam longint unsigned SEC_MS  = 64'd1000;

  // quotient bits of each long division
  localparam int QD_W = TOT_W - 27;
  localparam int QH_W = 5;
  localparam int QM_W = 6;
  localparam int QS_W = 6;

  // signed day count and days before january first of the input year
  localparam int DIN_W = QD_W + 1;
  localparam int BEF_W = 23;
  localparam int AW    = ((DIN_W > BEF_W + 1) ? DIN_W : BEF_W + 1) + 1;

  localparam longint unsigned ERA_DAYS = 64'd146097;
  localparam int ERA_YEARS = 400;
  localparam int QE_W  = AW - 18;
  localparam int YR_W  = QE_W + 11;

  localparam int CENT_DAYS = 36524;
  localparam int QUAD_DAYS = 1460;
  localparam int YEAR_DAYS = 365;

  localparam int YEAR_MIN = 1;
  localparam int YEAR_MAX = 9999;

  // reciprocal of 100, exact for values below 43699
  localparam int RECIP100    = 5243;
  localparam int RECIP100_SH = 19;

  localparam int CNT_W = $clog2(QD_W);

  // divisors pre-shifted to the top quotient bit
  localparam logic [U_W-1:0] DVS_DAY0  = U_W'(DAY_MS) << (QD_W - 1);
  localparam logic [U_W-1:0] DVS_HOUR0 = U_W'(HOUR_MS) << (QH_W - 1);
  localparam logic [U_W-1:0] DVS_MIN0  = U_W'(MIN_MS) << (QM_W - 1);
  localparam logic [U_W-1:0] DVS_SEC0  = U_W'(SEC_MS) << (QS_W - 1);
  localparam logic [U_W-1:0] DVS_ERA0  = U_W'(ERA_DAYS) << (QE_W - 1);

  // cumulative days before each month, common year then leap year
  localparam logic [8:0] CUM_DAYS [2][13] = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
      9'd304, 9'd334, 9'd365},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244, 9'd274,
      9'd305, 9'd335, 9'd366}
  };

  typedef struct packed {
    logic [13:0]                   year_in;
    logic [8:0]                    day_of_year_in;
    logic [4:0]                    hour_in;
    logic [5:0]                    minute_in;
    logic [5:0]                    second_in;
    logic [9:0]                    milli_in;
    logic signed [SHIFT_BITS-1:0]  shift_ms;
  } tsn_in_t;

  typedef struct packed {
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [8:0]  day_of_year_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [9:0]  milli_out;
    logic        out_of_range;
  } tsn_out_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } tsn_md_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DDIV,
    ST_DFIX,
    ST_HDIV,
    ST_MDIV,
    ST_SDIV,
    ST_EPREP,
    ST_EDIV,
    ST_EFIX,
    ST_W100,
    ST_W4,
    ST_W1,
    ST_YEAR,
    ST_FIN
  } tsn_state_t;

  // leap rule for a year offset 0..399 inside a 400 year era
  function automatic logic leap_off(input logic [8:0] yoff);
    logic cent;
    cent = (yoff == 9'd100) || (yoff == 9'd200) || (yoff == 9'd300);
    return (yoff[1:0] == 2'd0) && !cent;
  endfunction

  // zero based day of year to month and day of month
  function automatic tsn_md_t month_day(input logic [8:0] doy0, input logic lp);
    tsn_md_t r;
    r.month = 4'd1;
    r.day   = 5'(doy0 + 9'd1);
    for (int i = 0; i < 12; i++) begin
      if (doy0 >= CUM_DAYS[lp][i] && doy0 < CUM_DAYS[lp][i+1]) begin
        r.month = 4'(i + 1);
        r.day   = 5'(doy0 - CUM_DAYS[lp][i] + 9'd1);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tsn_alu.sv -----
// ----------------------------------------------------------------------------
// tsn_alu: shared subtract and compare unit
// one unsigned subtract whose borrow doubles as the greater-or-equal flag
// ----------------------------------------------------------------------------
`default_nettype none

module tsn_alu (
  input  logic [tsn_pkg::U_W-1:0] a,
  input  logic [tsn_pkg::U_W-1:0] b,
  output logic                    ge,
  output logic [tsn_pkg::U_W-1:0] diff
);
  import tsn_pkg::*;

  logic [U_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[U_W];
  assign diff = wide[U_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/tsn_core.sv -----
// ----------------------------------------------------------------------------
// tsn_core: timestamp shift sequencer
// sequences long divisions and the calendar walk over the shared alu
// ----------------------------------------------------------------------------
`default_nettype none

module tsn_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsn_pkg::tsn_in_t   in_data,
  output logic               res_valid,
  input  logic               res_take,
  output tsn_pkg::tsn_out_t  res_data
);
  import tsn_pkg::*;

  localparam logic [CNT_W-1:0] ACC_HOUR  = CNT_W'(0);
  localparam logic [CNT_W-1:0] ACC_MIN   = CNT_W'(1);
  localparam logic [CNT_W-1:0] ACC_SEC   = CNT_W'(2);
  localparam logic [CNT_W-1:0] ACC_MS    = CNT_W'(3);
  localparam logic [CNT_W-1:0] ACC_SHIFT = CNT_W'(4);

  localparam logic signed [YR_W-1:0] YMIN = YR_W'(YEAR_MIN);
  localparam logic signed [YR_W-1:0] YMAX = YR_W'(YEAR_MAX);

  tsn_state_t state_r, state_nxt;
  tsn_in_t    item_r, item_nxt;

  logic [U_W-1:0]   rem_r, rem_nxt;
  logic [U_W-1:0]   dvs_r, dvs_nxt;
  logic [QD_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;

  logic signed [DIN_W-1:0] days_r, days_nxt;
  logic [4:0]              hh_r, hh_nxt;
  logic [5:0]              mi_r, mi_nxt;
  logic [5:0]              ss_r, ss_nxt;
  logic [9:0]              ms_r, ms_nxt;
  logic signed [QE_W:0]    q400_r, q400_nxt;
  logic [8:0]              yoff_r, yoff_nxt;
  logic signed [YR_W-1:0]  year_r, year_nxt;

  // days before january first of the input year, counted from year zero
  logic [13:0]      yb_r, yb_nxt;
  logic [27:0]      m100_r, m100_nxt;
  logic [27:0]      m400_r, m400_nxt;
  logic [BEF_W-1:0] y365_r, y365_nxt;
  logic [BEF_W-1:0] before_r, before_nxt;

  logic [U_W-1:0] alu_a, alu_b, alu_diff;
  logic           alu_ge;

  logic [U_W-1:0]  rem_step;
  logic [QD_W-1:0] quo_step;

  logic signed [TOT_W-1:0] acc_s, add_s, acc_val;
  logic signed [10:0]      k_s;
  logic signed [AW-1:0]    era_sum;
  logic [AW-1:0]           era_mag;
  logic signed [YR_W-1:0]  q_ext;

  tsn_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .ge   (alu_ge),
    .diff (alu_diff)
  );

  assign m100_nxt   = (28'(item_r.year_in) + 28'd99) * 28'(RECIP100);
  assign m400_nxt   = (28'(item_r.year_in) + 28'd399) * 28'(RECIP100);
  assign y365_nxt   = BEF_W'(item_r.year_in) * BEF_W'(YEAR_DAYS);
  assign yb_nxt     = item_r.year_in;
  assign before_nxt = y365_r + BEF_W'((BEF_W'(yb_r) + BEF_W'(3)) >> 2)
                      - BEF_W'(m100_r >> RECIP100_SH)
                      + BEF_W'(m400_r >> (RECIP100_SH + 2));

  // day and time of day accumulate, then the shift: acc * k + field
  always_comb begin
    acc_s = signed'(rem_r);
    unique case (cnt_r)
      ACC_HOUR: begin
        k_s   = 11'sd24;
        add_s = signed'(TOT_W'(item_r.hour_in));
      end
      ACC_MIN: begin
        k_s   = 11'sd60;
        add_s = signed'(TOT_W'(item_r.minute_in));
      end
      ACC_SEC: begin
        k_s   = 11'sd60;
        add_s = signed'(TOT_W'(item_r.second_in));
      end
      ACC_MS: begin
        k_s   = 11'sd1000;
        add_s = signed'(TOT_W'(item_r.milli_in));
      end
      default: begin
        k_s   = 11'sd1;
        add_s = {{(TOT_W-SHIFT_BITS){item_r.shift_ms[SHIFT_BITS-1]}}, item_r.shift_ms};
      end
    endcase
    acc_val = acc_s * k_s + add_s;
  end

  assign era_sum = AW'(days_r) + signed'(AW'(before_r));
  assign era_mag = era_sum[AW-1] ? ~era_sum : era_sum;
  assign q_ext   = YR_W'(q400_r);

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    days_nxt  = days_r;
    hh_nxt    = hh_r;
    mi_nxt    = mi_r;
    ss_nxt    = ss_r;
    ms_nxt    = ms_r;
    q400_nxt  = q400_r;
    yoff_nxt  = yoff_r;
    year_nxt  = year_r;
    alu_a     = rem_r;
    alu_b     = dvs_r;
    rem_step  = alu_ge ? alu_diff : rem_r;
    quo_step  = {quo_r[QD_W-2:0], alu_ge};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          rem_nxt   = U_W'(in_data.day_of_year_in) - U_W'(1);
          cnt_nxt   = ACC_HOUR;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        rem_nxt = U_W'(acc_val);
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == ACC_SHIFT) begin
          // fold negatives to ~total so the division stays unsigned
          neg_nxt   = acc_val[TOT_W-1];
          rem_nxt   = acc_val[TOT_W-1] ? ~U_W'(acc_val) : U_W'(acc_val);
          dvs_nxt   = DVS_DAY0;
          quo_nxt   = '0;
          cnt_nxt   = CNT_W'(QD_W - 1);
          state_nxt = ST_DDIV;
        end
      end
      ST_DDIV, ST_HDIV, ST_MDIV, ST_SDIV, ST_EDIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          quo_nxt = '0;
          unique case (state_r)
            ST_DDIV: begin
              quo_nxt   = quo_step;
              state_nxt = ST_DFIX;
            end
            ST_HDIV: begin
              hh_nxt    = quo_step[QH_W-1:0];
              dvs_nxt   = DVS_MIN0;
              cnt_nxt   = CNT_W'(QM_W - 1);
              state_nxt = ST_MDIV;
            end
            ST_MDIV: begin
              mi_nxt    = quo_step[QM_W-1:0];
              dvs_nxt   = DVS_SEC0;
              cnt_nxt   = CNT_W'(QS_W - 1);
              state_nxt = ST_SDIV;
            end
            ST_SDIV: begin
              ss_nxt    = quo_step[QS_W-1:0];
              ms_nxt    = rem_step[9:0];
              state_nxt = ST_EPREP;
            end
            default: begin
              quo_nxt   = quo_step;
              state_nxt = ST_EFIX;
            end
          endcase
        end
      end
      ST_DFIX: begin
        // floor correction: days = -q-1, time of day = one day - 1 - r
        alu_a     = U_W'(DAY_MS - 64'd1);
        alu_b     = rem_r;
        days_nxt  = neg_r ? ~signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});
        rem_nxt   = neg_r ? alu_diff : rem_r;
        dvs_nxt   = DVS_HOUR0;
        quo_nxt   = '0;
        cnt_nxt   = CNT_W'(QH_W - 1);
        state_nxt = ST_HDIV;
      end
      ST_EPREP: begin
        neg_nxt   = era_sum[AW-1];
        rem_nxt   = U_W'(era_mag);
        dvs_nxt   = DVS_ERA0;
        quo_nxt   = '0;
        cnt_nxt   = CNT_W'(QE_W - 1);
        state_nxt = ST_EDIV;
      end
      ST_EFIX: begin
        alu_a     = U_W'(ERA_DAYS - 64'd1);
        alu_b     = rem_r;
        q400_nxt  = neg_r ? ~signed'({1'b0, quo_r[QE_W-1:0]})
                          : signed'({1'b0, quo_r[QE_W-1:0]});
        rem_nxt   = neg_r ? alu_diff : rem_r;
        yoff_nxt  = '0;
        state_nxt = ST_W100;
      end
      ST_W100: begin
        alu_b = (yoff_r == '0) ? U_W'(CENT_DAYS + 1) : U_W'(CENT_DAYS);
        if (alu_ge) begin
          rem_nxt  = alu_diff;
          yoff_nxt = yoff_r + 9'd100;
        end else begin
          state_nxt = ST_W4;
        end
      end
      ST_W4: begin
        alu_b = leap_off(yoff_r) ? U_W'(QUAD_DAYS + 1) : U_W'(QUAD_DAYS);
        if (alu_ge) begin
          rem_nxt  = alu_diff;
          yoff_nxt = yoff_r + 9'd4;
        end else begin
          state_nxt = ST_W1;
        end
      end
      ST_W1: begin
        alu_b = leap_off(yoff_r) ? U_W'(YEAR_DAYS + 1) : U_W'(YEAR_DAYS);
        if (alu_ge) begin
          rem_nxt  = alu_diff;
          yoff_nxt = yoff_r + 9'd1;
        end else begin
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        year_nxt  = q_ext * signed'(YR_W'(ERA_YEARS)) + signed'(YR_W'(yoff_r));
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result word with saturation
  always_comb begin
    logic [8:0] doy0;
    logic       lp;
    tsn_md_t    md;
    res_data.year_out     = year_r[13:0];
    res_data.hour_out     = hh_r;
    res_data.minute_out   = mi_r;
    res_data.second_out   = ss_r;
    res_data.milli_out    = ms_r;
    res_data.out_of_range = 1'b0;
    doy0                  = rem_r[8:0];
    lp                    = leap_off(yoff_r);
    priority if (year_r < YMIN) begin
      res_data.year_out     = 14'(YEAR_MIN);
      res_data.hour_out     = 5'd0;
      res_data.minute_out   = 6'd0;
      res_data.second_out   = 6'd0;
      res_data.milli_out    = 10'd0;
      res_data.out_of_range = 1'b1;
      doy0                  = 9'd0;
      lp                    = 1'b0;
    end else if (year_r > YMAX) begin
      res_data.year_out     = 14'(YEAR_MAX);
      res_data.hour_out     = 5'd23;
      res_data.minute_out   = 6'd59;
      res_data.second_out   = 6'd59;
      res_data.milli_out    = 10'd999;
      res_data.out_of_range = 1'b1;
      doy0                  = 9'd364;
      lp                    = 1'b0;
    end else begin
      lp = leap_off(yoff_r);
    end
    md                       = month_day(doy0, lp);
    res_data.month_out       = md.month;
    res_data.day_out         = md.day;
    res_data.day_of_year_out = doy0 + 9'd1;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    days_r   <= days_nxt;
    hh_r     <= hh_nxt;
    mi_r     <= mi_nxt;
    ss_r     <= ss_nxt;
    ms_r     <= ms_nxt;
    q400_r   <= q400_nxt;
    yoff_r   <= yoff_nxt;
    year_r   <= year_nxt;
    yb_r     <= yb_nxt;
    m100_r   <= m100_nxt;
    m400_r   <= m400_nxt;
    y365_r   <= y365_nxt;
    before_r <= before_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/timestamp_shift_normalize.sv -----
// ----------------------------------------------------------------------------
// timestamp_shift_normalize: shift a day-of-year timestamp by signed ms
// adds a millisecond shift and renormalizes to gregorian date and time
// ----------------------------------------------------------------------------
// usage
//   input word (in_valid / in_ready / in_data): year, day of year, hour,
//   minute, second, millisecond and a signed 40 bit shift in milliseconds.
//   result word (out_valid / out_ready / out_data): normalized year, month,
//   day, day of year, time of day and an out-of-range flag; years that fall
//   outside 1..9999 saturate to the first or last instant of that range.
//   one word in at a time: in_ready is high only while the sequencer idles.
//   each word runs through 5 accumulate steps, a 15 step day division,
//   17 steps splitting the time of day, a 7 step 400 year era division,
//   then a walk of up to 4 century, 25 four-year and 4 single-year steps,
//   plus fix-up and output states. every division step and walk step goes
//   through the one shared subtract / compare unit. a new word is taken
//   only once the previous result has left the sequencer.
//   the result sits in an output register, so a new word is accepted while
//   the receiver stalls; the sequencer then waits with its next result until
//   the register frees up.
//   reset (rst_n low, synchronous) returns the sequencer to idle and empties
//   the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_shift_normalize (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsn_pkg::tsn_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tsn_pkg::tsn_out_t  out_data
);
  import tsn_pkg::*;

  logic      res_valid;
  logic      res_take;
  tsn_out_t  res_data;

  logic      out_valid_r, out_valid_nxt;
  tsn_out_t  out_r, out_nxt;

  // sequencer: divisions, era and year walk, month lookup
  tsn_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data)
  );

  // output register takes a result when empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // one word at a time through the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer took a second word while busy");

  // a saturated result sits on a range edge
  a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_of_range) |->
      (out_data.year_out == 14'(YEAR_MIN) || out_data.year_out == 14'(YEAR_MAX)))
    else $error("out of range result not at a year edge");

  // normalized fields stay in their calendar ranges
  a_fields_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.month_out >= 4'd1 && out_data.month_out <= 4'd12 &&
                   out_data.hour_out <= 5'd23 && out_data.minute_out <= 6'd59 &&
                   out_data.second_out <= 6'd59 && out_data.milli_out <= 10'd999))
    else $error("result field out of calendar range");

  // a new result only comes from a finished sequence
  a_rise_from_core: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_valid))
    else $error("output register loaded without a finished result");

endmodule

`default_nettype wire

// ----- tb/sv/timestamp_shift_normalize_tb.sv -----
// ----------------------------------------------------------------------------
// timestamp_shift_normalize_tb: self-checking bench for the timestamp shifter
// drives timestamps with signed millisecond shifts through the valid / ready
// input, predicts each normalized date and time in the bench and compares
// every result word field by field, with random gaps and receiver stalls
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_shift_normalize_tb;

  import tsn_pkg::*;

  // run limit in clock cycles, far above the slowest legal run
  localparam int CYCLE_LIMIT = 1500000;
  // cycles to wait after the last result
  localparam int DRAIN_CYCLES = 120;
  // receiver hold-off length for the back-pressure test
  localparam int HOLD_CYCLES = 400;
  localparam longint MS_DAY = 86400000;
  localparam longint ERA_LEN = 146097;
  // bits in one input word
  localparam int IN_BITS = $bits(tsn_in_t);

  // days before each month, common year then leap year
  localparam int MONTH_START [2][13] = '{
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
    '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
  };

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tsn_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tsn_out_t out_data;

  // expected normalized timestamps, oldest first
  tsn_out_t pending_dates[$];
  int       mismatches = 0;
  int       cycles = 0;
  // idling switches for each side, and a request for one long receiver stall
  bit       send_idle = 1'b1;
  bit       recv_idle = 1'b1;
  bit       hold_req = 1'b0;

  timestamp_shift_normalize dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("timestamp_shift_normalize test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // calendar predictor
  // ---------------------------------------------------------------------------

  // proleptic gregorian rule, also valid for year 0 and below
  function automatic bit leap_year(longint y);
    longint r;
    r = y % 400;
    if (r < 0) r += 400;
    return (r == 0) || ((r % 100 != 0) && (r % 4 == 0));
  endfunction

  function automatic longint year_length(longint y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic tsn_out_t normalize_timestamp(tsn_in_t w);
    longint   yr, total, days, tod, shift, doy;
    longint   hh, mi, ss, ms;
    int       mo, dd, lp;
    bit       clipped;
    tsn_out_t r;
    yr    = w.year_in;
    doy   = w.day_of_year_in;
    // sign-extend the shift to 64 bits
    shift = {{(64-SHIFT_BITS){w.shift_ms[SHIFT_BITS-1]}}, w.shift_ms};
    total = ((((doy - 1) * 24 + longint'(w.hour_in)) * 60 + longint'(w.minute_in)) * 60
             + longint'(w.second_in)) * 1000 + longint'(w.milli_in) + shift;
    // floor division into whole days and time of day
    days = total / MS_DAY;
    if ((total % MS_DAY) != 0 && total < 0) days -= 1;
    tod = total - days * MS_DAY;
    // walk whole eras, then single years
    while (days >= ERA_LEN) begin
      days -= ERA_LEN;
      yr += 400;
    end
    while (days < 0) begin
      days += ERA_LEN;
      yr -= 400;
    end
    while (days >= year_length(yr)) begin
      days -= year_length(yr);
      yr += 1;
    end
    ms = tod % 1000;
    ss = (tod / 1000) % 60;
    mi = (tod / 60000) % 60;
    hh = tod / 3600000;
    clipped = 1'b0;
    if (yr < 1) begin
      yr = 1; days = 0; hh = 0; mi = 0; ss = 0; ms = 0;
      clipped = 1'b1;
    end else if (yr > 9999) begin
      yr = 9999; days = 364; hh = 23; mi = 59; ss = 59; ms = 999;
      clipped = 1'b1;
    end
    lp = leap_year(yr);
    mo = 1;
    dd = int'(days) + 1;
    for (int i = 0; i < 12; i++) begin
      if (days >= MONTH_START[lp][i] && days < MONTH_START[lp][i+1]) begin
        mo = i + 1;
        dd = int'(days) - MONTH_START[lp][i] + 1;
      end
    end
    r.year_out        = 14'(yr);
    r.month_out       = 4'(mo);
    r.day_out         = 5'(dd);
    r.day_of_year_out = 9'(days + 1);
    r.hour_out        = 5'(hh);
    r.minute_out      = 6'(mi);
    r.second_out      = 6'(ss);
    r.milli_out       = 10'(ms);
    r.out_of_range    = clipped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tsn_in_t make_stamp(int y, int doy, int h, int m, int s, int ms,
                                         longint shift);
    tsn_in_t w;
    w.year_in        = 14'(y);
    w.day_of_year_in = 9'(doy);
    w.hour_in        = 5'(h);
    w.minute_in      = 6'(m);
    w.second_in      = 6'(s);
    w.milli_in       = 10'(ms);
    w.shift_ms       = shift[SHIFT_BITS-1:0];
    return w;
  endfunction

  // mostly back-to-back, sometimes a few cycles, rarely a long pause
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // log-spread magnitude up to maxbits, random sign
  function automatic longint rand_shift(int maxbits);
    longint mag;
    int     k;
    k   = $urandom_range(1, maxbits);
    mag = {$urandom, $urandom};
    mag = mag & ((longint'(1) << k) - 1);
    if ($urandom_range(0, 1)) mag = -mag;
    return mag;
  endfunction

  // nominal timestamp inside years 1..9999
  function automatic tsn_in_t nominal_stamp(int ylo, int yhi, longint shift);
    int y;
    y = $urandom_range(ylo, yhi);
    return make_stamp(y, $urandom_range(1, int'(year_length(y))), $urandom_range(0, 23),
                      $urandom_range(0, 59), $urandom_range(0, 59),
                      $urandom_range(0, 999), shift);
  endfunction

  // one input word: optional gap, then hold valid until accepted
  task automatic send_word(tsn_in_t w);
    int gap;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back(normalize_timestamp(w));
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_date(tsn_out_t got);
    tsn_out_t want;
    if (pending_dates.size() == 0) begin
      report_mismatch("result word with nothing pending, year", got.year_out, 0);
      return;
    end
    want = pending_dates.pop_front();
    if (got.year_out != want.year_out)
      report_mismatch("year_out", got.year_out, want.year_out);
    if (got.month_out != want.month_out)
      report_mismatch("month_out", got.month_out, want.month_out);
    if (got.day_out != want.day_out)
      report_mismatch("day_out", got.day_out, want.day_out);
    if (got.day_of_year_out != want.day_of_year_out)
      report_mismatch("day_of_year_out", got.day_of_year_out, want.day_of_year_out);
    if (got.hour_out != want.hour_out)
      report_mismatch("hour_out", got.hour_out, want.hour_out);
    if (got.minute_out != want.minute_out)
      report_mismatch("minute_out", got.minute_out, want.minute_out);
    if (got.second_out != want.second_out)
      report_mismatch("second_out", got.second_out, want.second_out);
    if (got.milli_out != want.milli_out)
      report_mismatch("milli_out", got.milli_out, want.milli_out);
    if (got.out_of_range != want.out_of_range)
      report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
  endtask

  // receiver: samples the handshake at each edge, then picks the next ready
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_date(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        // long hold-off so the output register fills and the input stalls
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap(recv_idle);
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes and calendar corner cases
  task automatic test_directed();
    // identity and leap day
    send_word(make_stamp(2024, 1, 0, 0, 0, 0, 0));
    send_word(make_stamp(2024, 60, 12, 30, 15, 500, 0));
    // year rollover, common and leap year
    send_word(make_stamp(2023, 365, 23, 59, 59, 999, 1));
    send_word(make_stamp(2024, 366, 23, 59, 59, 999, 1));
    // one ms back across march first in a leap year
    send_word(make_stamp(2024, 61, 0, 0, 0, 0, -1));
    // negative shifts landing on a whole minute, second must read 0
    send_word(make_stamp(2024, 1, 0, 1, 0, 0, -60000));
    send_word(make_stamp(2024, 1, 0, 2, 30, 0, -30000));
    send_word(make_stamp(2024, 10, 5, 0, 0, 0, -3600000 * 7));
    // century rule: 1900 common, 2000 and 1600 leap, 2100 common
    send_word(make_stamp(1900, 59, 0, 0, 0, 0, MS_DAY));
    send_word(make_stamp(2000, 59, 0, 0, 0, 0, MS_DAY));
    send_word(make_stamp(1600, 366, 0, 0, 0, 0, 0));
    send_word(make_stamp(2100, 60, 0, 0, 0, 0, 0));
    // result before year 1 and after year 9999
    send_word(make_stamp(1, 1, 0, 0, 0, 0, -1));
    send_word(make_stamp(9999, 365, 23, 59, 59, 999, 1));
    // year 0 taken at face value, and day of year 0
    send_word(make_stamp(0, 1, 0, 0, 0, 0, 0));
    send_word(make_stamp(0, 366, 0, 0, 0, 0, MS_DAY));
    send_word(make_stamp(1, 0, 0, 0, 0, 0, 0));
    // top bit patterns: all fields, then the time of day fields alone
    send_word(make_stamp(16383, 511, 31, 63, 63, 1023, 0));
    send_word(make_stamp(2024, 1, 31, 63, 63, 1023, 0));
    // shift extremes
    send_word(make_stamp(16383, 511, 31, 63, 63, 1023, (longint'(1) << 39) - 1));
    send_word(make_stamp(16383, 511, 31, 63, 63, 1023, -(longint'(1) << 39)));
    send_word(make_stamp(9999, 1, 0, 0, 0, 0, -(longint'(1) << 39)));
    send_word(make_stamp(2000, 1, 0, 0, 0, 0, (longint'(1) << 39) - 1));
    send_word(make_stamp(0, 0, 0, 0, 0, 0, 0));
  endtask

  // random mix: nominal stamps, edge years, whole-minute steps, raw bits
  task automatic test_random(int count);
    int      kind;
    longint  shift;
    tsn_in_t w;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        w = nominal_stamp(1, 9999, rand_shift(40));
      end else if (kind < 65) begin
        // near the range edges, shifts of up to a few years
        if ($urandom_range(0, 1)) w = nominal_stamp(1, 3, rand_shift(37));
        else w = nominal_stamp(9997, 9999, rand_shift(37));
      end else if (kind < 78) begin
        // whole minute start, negative whole minute shift
        shift = -(longint'($urandom_range(1, 2000000)) * 60000);
        w = nominal_stamp(1, 9999, shift);
        w.second_in = '0;
        w.milli_in  = '0;
      end else if (kind < 88) begin
        w = nominal_stamp(1, 9999, {$urandom, $urandom});
      end else begin
        // every field at raw random bits
        w = IN_BITS'({$urandom, $urandom, $urandom});
      end
      send_word(w);
    end
  endtask

  // receiver stops for a long stretch while the sender keeps offering words
  task automatic test_backpressure();
    send_idle = 1'b0;
    hold_req  = 1'b1;
    for (int n = 0; n < 12; n++)
      send_word(nominal_stamp(1, 9999, rand_shift(40)));
    send_idle = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    // a stretch with no idling on either side
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random(350);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_backpressure();
    test_random(1060);

    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("timestamp_shift_normalize test passed");
    end else begin
      $display("timestamp_shift_normalize test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/tsn_pkg.sv
rtl/tsn_alu.sv
rtl/tsn_core.sv
rtl/timestamp_shift_normalize.sv
tb/sv/timestamp_shift_normalize_tb.sv
